/* rtl/core/assert_macros.svh */
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, off while in reset
`define ATS_ASSERT_RST(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// checked property, always on
`define ATS_ASSERT(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

/* rtl/core/ats_pkg.sv */
// types, constants and tables of the arm tip speed estimator
package ats_pkg;

  localparam int ANG_W       = 16;
  localparam int CORDIC_W    = 34;
  localparam int MRAD_LIMIT  = 3142;
  localparam int PI_Q13      = 25736;
  localparam int HALF_PI_Q13 = 12868;
  localparam int TWO_PI_Q13  = 51472;
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [19:0] SPEED_MAX = 20'hFFFFF;
  localparam logic [31:0] PREV_TIME_RESET = 32'd1000;
  localparam logic [19:0] UPPER_LINK_RESET = 20'd220000;
  localparam logic [19:0] FOREARM_RESET = 20'd150000;
  localparam logic [19:0] BASE_HEIGHT_RESET = 20'd55000;

  localparam logic [1:0] REG_UPPER_LINK  = 2'd0;
  localparam logic [1:0] REG_FOREARM     = 2'd1;
  localparam logic [1:0] REG_BASE_HEIGHT = 2'd2;

  typedef struct packed {
    logic signed [ANG_W-1:0] ang_base;
    logic signed [ANG_W-1:0] ang_shoulder;
    logic signed [ANG_W-1:0] ang_elbow;
    logic [31:0]             ts;
  } job_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:    v = 34'sd843314857;
      5'd1:    v = 34'sd497837829;
      5'd2:    v = 34'sd263043837;
      5'd3:    v = 34'sd133525159;
      5'd4:    v = 34'sd67021687;
      5'd5:    v = 34'sd33543516;
      5'd6:    v = 34'sd16775851;
      5'd7:    v = 34'sd8388437;
      5'd8:    v = 34'sd4194283;
      5'd9:    v = 34'sd2097149;
      5'd10:   v = 34'sd1048576;
      5'd11:   v = 34'sd524288;
      5'd12:   v = 34'sd262144;
      5'd13:   v = 34'sd131072;
      5'd14:   v = 34'sd65536;
      5'd15:   v = 34'sd32768;
      5'd16:   v = 34'sd16384;
      5'd17:   v = 34'sd8192;
      5'd18:   v = 34'sd4096;
      5'd19:   v = 34'sd2048;
      5'd20:   v = 34'sd1024;
      5'd21:   v = 34'sd512;
      5'd22:   v = 34'sd256;
      5'd23:   v = 34'sd128;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/arm_tip_speed_estimator_unit.sv */
// top level of the arm tip position and speed estimator
//
//  port group      direction  handshake
//  joint/time in   in         push, full
//  tip/speed out   out        empty, pop
//  config write    in         cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// the time an item takes in the back end is set by the shared cordic,
// the one-bit-per-cycle root and the one-bit-per-cycle speed divider
// zero elapsed time skips the divider, an invalid mean skips the averaging
// the front end converts the next item while the back end works
// reset is asynchronous and active low; no clearing pass is needed
// a result waiting in the output register holds the back end only at its last step
module arm_tip_speed_estimator_unit #(
  parameter int AVERAGE_TAPS      = 3,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [12:0]        joint_base_mrad_i,
  input  logic [12:0]        joint_shoulder_mrad_i,
  input  logic [12:0]        joint_elbow_mrad_i,
  input  logic [31:0]        timestamp_us_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [19:0] tip_x_um_o,
  output logic signed [19:0] tip_y_um_o,
  output logic signed [19:0] tip_z_um_o,
  output logic [19:0]        speed_mm_s_o,
  output logic [19:0]        mean_speed_mm_s_o,
  output logic               mean_valid_o,
  output logic [19:0]        peak_mean_mm_s_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [19:0]        cfg_wdata_i
);

  logic [19:0] upper_q, forearm_q, base_q;

  ats_pkg::job_t f_data, b_data;
  logic          f_push, q_full, q_pop, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q   <= ats_pkg::UPPER_LINK_RESET;
      forearm_q <= ats_pkg::FOREARM_RESET;
      base_q    <= ats_pkg::BASE_HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ats_pkg::REG_UPPER_LINK:  upper_q   <= cfg_wdata_i;
        ats_pkg::REG_FOREARM:     forearm_q <= cfg_wdata_i;
        ats_pkg::REG_BASE_HEIGHT: base_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ats_front u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .push                  (push),
    .full                  (full),
    .joint_base_mrad_i     (joint_base_mrad_i),
    .joint_shoulder_mrad_i (joint_shoulder_mrad_i),
    .joint_elbow_mrad_i    (joint_elbow_mrad_i),
    .timestamp_us_i        (timestamp_us_i),
    .q_full_i              (q_full),
    .q_push_o              (f_push),
    .q_data_o              (f_data)
  );

  ats_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (f_push),
    .wdata_i (f_data),
    .full_o  (q_full),
    .rd_i    (q_pop),
    .rdata_o (b_data),
    .empty_o (q_empty)
  );

  ats_back #(
    .AVERAGE_TAPS      (AVERAGE_TAPS),
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .q_pop_o           (q_pop),
    .q_data_i          (b_data),
    .upper_link_um_i   (upper_q),
    .forearm_um_i      (forearm_q),
    .base_height_um_i  (base_q),
    .pop               (pop),
    .empty             (empty),
    .tip_x_um_o        (tip_x_um_o),
    .tip_y_um_o        (tip_y_um_o),
    .tip_z_um_o        (tip_z_um_o),
    .speed_mm_s_o      (speed_mm_s_o),
    .mean_speed_mm_s_o (mean_speed_mm_s_o),
    .mean_valid_o      (mean_valid_o),
    .peak_mean_mm_s_o  (peak_mean_mm_s_o)
  );

endmodule

/* rtl/core/ats_front.sv */
// front end: takes input words and converts the joint angles to q3.13 radians
module ats_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [12:0]        joint_base_mrad_i,
  input  logic [12:0]        joint_shoulder_mrad_i,
  input  logic [12:0]        joint_elbow_mrad_i,
  input  logic [31:0]        timestamp_us_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output ats_pkg::job_t      q_data_o
);

  typedef enum logic [1:0] {F_IDLE, F_CONV, F_PUSH} fstate_e;

  fstate_e       st_q;
  logic [1:0]    idx_q;
  logic [12:0]   raw_q [3];
  ats_pkg::job_t job_q;
  logic signed [ats_pkg::ANG_W-1:0] conv;

  function automatic logic signed [15:0] mrad_to_q13(input logic [12:0] raw);
    logic signed [12:0] m;
    logic [11:0] mag;
    logic [24:0] n;
    logic [47:0] prod;
    logic [14:0] q0;
    logic [24:0] back;
    logic [24:0] r;
    logic [14:0] q;
    m = signed'(raw);
    if (m > 13'(ats_pkg::MRAD_LIMIT) || m < -13'(ats_pkg::MRAD_LIMIT)) begin
      mag = 12'(ats_pkg::MRAD_LIMIT);
    end else if (m < 0) begin
      mag = 12'(-m);
    end else begin
      mag = 12'(m);
    end
    n    = {mag, 13'd0} + 25'd500;
    prod = 48'(n) * 48'd4294967;
    q0   = prod[46:32];
    back = {q0, 10'd0} - 25'({q0, 4'd0}) - 25'({q0, 3'd0});
    r    = n - back;
    q    = (r >= 25'd1000) ? q0 + 15'd1 : q0;
    return (m < 0) ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  assign conv     = mrad_to_q13(raw_q[idx_q]);
  assign full     = (st_q != F_IDLE);
  assign q_push_o = (st_q == F_PUSH) && !q_full_i;
  assign q_data_o = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= F_IDLE;
      idx_q  <= 2'd0;
      raw_q  <= '{default: '0};
      job_q  <= '0;
    end else begin
      case (st_q)
        F_IDLE: begin
          if (push) begin
            raw_q[0] <= joint_base_mrad_i;
            raw_q[1] <= joint_shoulder_mrad_i;
            raw_q[2] <= joint_elbow_mrad_i;
            job_q.ts <= timestamp_us_i;
            idx_q    <= 2'd0;
            st_q     <= F_CONV;
          end
        end
        F_CONV: begin
          case (idx_q)
            2'd0:    job_q.ang_base     <= conv;
            2'd1:    job_q.ang_shoulder <= conv;
            default: job_q.ang_elbow    <= conv;
          endcase
          if (idx_q == 2'd2) begin
            st_q <= F_PUSH;
          end else begin
            idx_q <= idx_q + 2'd1;
          end
        end
        F_PUSH: begin
          if (!q_full_i) begin
            st_q <= F_IDLE;
          end
        end
        default: st_q <= F_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/ats_fifo.sv */
// short queue of converted jobs between front and back end
module ats_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  ats_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          rd_i,
  output ats_pkg::job_t rdata_o,
  output logic          empty_o
);

  localparam int DEPTH = ats_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  ats_pkg::job_t mem_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic          do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
      mem_q <= '{default: '0};
    end else begin
      if (do_wr) begin
        mem_q[wp_q] <= wdata_i;
        wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
      end
      if (do_rd) begin
        rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

/* rtl/core/ats_back.sv */
// back end: cordic, kinematics, distance root, speed divide and averaging
`include "assert_macros.svh"

module ats_back #(
  parameter int AVERAGE_TAPS      = 3,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  output logic                q_pop_o,
  input  ats_pkg::job_t       q_data_i,
  input  logic [19:0]         upper_link_um_i,
  input  logic [19:0]         forearm_um_i,
  input  logic [19:0]         base_height_um_i,
  input  logic                pop,
  output logic                empty,
  output logic signed [19:0]  tip_x_um_o,
  output logic signed [19:0]  tip_y_um_o,
  output logic signed [19:0]  tip_z_um_o,
  output logic [19:0]         speed_mm_s_o,
  output logic [19:0]         mean_speed_mm_s_o,
  output logic                mean_valid_o,
  output logic [19:0]         peak_mean_mm_s_o
);

  localparam int CW     = ats_pkg::CORDIC_W;
  localparam int CNT_W  = $clog2(AVERAGE_TAPS + 2);
  localparam int SUM_W  = 20 + $clog2(AVERAGE_TAPS + 1);
  localparam int TAP_IW = (AVERAGE_TAPS > 1) ? $clog2(AVERAGE_TAPS) : 1;
  localparam int MP_W   = SUM_W + 33;

  // rounded-up reciprocal of the tap count, exact for sums below 2^28
  localparam logic [32:0] MEAN_RECIP =
    33'(((longint'(1) << 32) + longint'(AVERAGE_TAPS) - 1) / longint'(AVERAGE_TAPS));

  typedef enum logic [3:0] {
    B_IDLE, B_ANGLE, B_CINIT, B_CRUN, B_CSTORE, B_MUL, B_SQRT, B_SPEED,
    B_DIV, B_HIST, B_SUM, B_MEAN_LD, B_MEAN_DONE, B_OUT
  } bstate_e;

  bstate_e st_q;
  ats_pkg::job_t job_q;

  logic signed [17:0]   ang_q [3];
  logic [1:0]           sel_q;
  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic                 neg_q;
  logic [4:0]           it_q;
  logic signed [CW-1:0] cos_q [3];
  logic signed [CW-1:0] sin_q [3];

  logic [3:0]           step_q;
  logic signed [CW-1:0] mul_a, mul_b;
  logic signed [67:0]   p_q, acc_q;
  logic signed [CW-1:0] reach_q;
  logic signed [19:0]   x_q, y_q, z_q;
  logic signed [19:0]   prev_x_q, prev_y_q, prev_z_q;
  logic [31:0]          prev_time_q;
  logic [41:0]          d2_q;
  logic signed [20:0]   dx, dy, dz;

  logic [63:0]          sq_n_q, sq_r_q, sq_b_q, sq_t;

  logic [32:0]          dv_num_q;
  logic [31:0]          dv_den_q, dv_rem_q;
  logic [32:0]          dv_shift;
  logic                 dv_ge;
  logic [5:0]           dv_cnt_q;
  logic [31:0]          dt;

  logic [19:0]          sp_q, mean_q, peak_q;
  logic [19:0]          hist_q [AVERAGE_TAPS];
  logic [CNT_W-1:0]     cnt_q;
  logic                 valid_q;
  logic [SUM_W-1:0]     sum_q;
  logic [TAP_IW-1:0]    tap_q;
  logic [MP_W-1:0]      mprod_q;
  logic [19:0]          mean_sat;

  logic                 out_valid_q;
  logic                 out_wr;

  logic signed [17:0]   b_ang, be_ang, fold;
  logic signed [CW-1:0] xs, ys;

  function automatic logic signed [17:0] wrap(input logic signed [17:0] a);
    if (a > 18'sd25736) begin
      return a - 18'(ats_pkg::TWO_PI_Q13);
    end else if (a < -18'sd25736) begin
      return a + 18'(ats_pkg::TWO_PI_Q13);
    end
    return a;
  endfunction

  function automatic logic signed [67:0] rnd68(input logic signed [67:0] v, input int s);
    logic [67:0] mag, half, q;
    half = 68'(1) << (s - 1);
    mag  = v[67] ? 68'(-v) : 68'(v);
    q    = (mag + half) >> s;
    return v[67] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [67:0] v);
    if (v > 68'sd524287) begin
      return 20'sd524287;
    end else if (v < -68'sd524288) begin
      return -20'sd524288;
    end
    return 20'(v);
  endfunction

  function automatic logic [19:0] sat_u20(input logic [32:0] v);
    return (v > 33'(ats_pkg::SPEED_MAX)) ? ats_pkg::SPEED_MAX : v[19:0];
  endfunction

  assign q_pop_o = (st_q == B_IDLE) && !q_empty_i;
  assign empty   = !out_valid_q;
  assign out_wr  = (st_q == B_OUT) && (!out_valid_q || pop);

  assign b_ang  = wrap(18'(job_q.ang_shoulder) + 18'(ats_pkg::HALF_PI_Q13));
  assign be_ang = wrap(b_ang + 18'(job_q.ang_elbow));

  always_comb begin
    fold = ang_q[sel_q];
    if (ang_q[sel_q] > 18'(ats_pkg::HALF_PI_Q13)) begin
      fold = ang_q[sel_q] - 18'(ats_pkg::PI_Q13);
    end else if (ang_q[sel_q] < -18'(ats_pkg::HALF_PI_Q13)) begin
      fold = ang_q[sel_q] + 18'(ats_pkg::PI_Q13);
    end
  end

  assign xs = cx_q >>> it_q;
  assign ys = cy_q >>> it_q;

  assign dx = 21'(x_q) - 21'(prev_x_q);
  assign dy = 21'(y_q) - 21'(prev_y_q);
  assign dz = 21'(z_q) - 21'(prev_z_q);

  always_comb begin
    case (step_q)
      4'd0:    begin mul_a = $signed({14'd0, upper_link_um_i}); mul_b = cos_q[1]; end
      4'd1:    begin mul_a = $signed({14'd0, forearm_um_i});    mul_b = cos_q[2]; end
      4'd2:    begin mul_a = $signed({14'd0, upper_link_um_i}); mul_b = sin_q[1]; end
      4'd3:    begin mul_a = $signed({14'd0, forearm_um_i});    mul_b = sin_q[2]; end
      4'd4:    begin mul_a = cos_q[0]; mul_b = reach_q; end
      4'd5:    begin mul_a = sin_q[0]; mul_b = reach_q; end
      4'd6:    begin mul_a = CW'(dx); mul_b = CW'(dx); end
      4'd7:    begin mul_a = CW'(dy); mul_b = CW'(dy); end
      4'd8:    begin mul_a = CW'(dz); mul_b = CW'(dz); end
      4'd10:   begin mul_a = $signed({13'd0, d2_q[41:21]}); mul_b = 34'sd1000000; end
      4'd11:   begin mul_a = $signed({13'd0, d2_q[20:0]});  mul_b = 34'sd1000000; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign sq_t     = sq_r_q + sq_b_q;
  assign dt       = job_q.ts - prev_time_q;
  assign dv_shift = {dv_rem_q, dv_num_q[32]};
  assign dv_ge    = dv_shift >= {1'b0, dv_den_q};
  assign mean_sat = sat_u20(33'(mprod_q >> 32));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      job_q       <= '0;
      ang_q       <= '{default: '0};
      sel_q       <= 2'd0;
      cx_q        <= '0;
      cy_q        <= '0;
      cz_q        <= '0;
      neg_q       <= 1'b0;
      it_q        <= '0;
      cos_q       <= '{default: '0};
      sin_q       <= '{default: '0};
      step_q      <= '0;
      p_q         <= '0;
      acc_q       <= '0;
      reach_q     <= '0;
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_z_q    <= '0;
      prev_time_q <= ats_pkg::PREV_TIME_RESET;
      d2_q        <= '0;
      sq_n_q      <= '0;
      sq_r_q      <= '0;
      sq_b_q      <= '0;
      dv_num_q    <= '0;
      dv_den_q    <= '0;
      dv_rem_q    <= '0;
      dv_cnt_q    <= '0;
      sp_q        <= '0;
      mean_q      <= '0;
      peak_q      <= '0;
      hist_q      <= '{default: '0};
      cnt_q       <= '0;
      valid_q     <= 1'b0;
      sum_q       <= '0;
      tap_q       <= '0;
      mprod_q     <= '0;
      out_valid_q <= 1'b0;
      tip_x_um_o  <= '0;
      tip_y_um_o  <= '0;
      tip_z_um_o  <= '0;
      speed_mm_s_o      <= '0;
      mean_speed_mm_s_o <= '0;
      mean_valid_o      <= 1'b0;
      peak_mean_mm_s_o  <= '0;
    end else begin
      p_q <= mul_a * mul_b;
      if (pop && out_valid_q && !out_wr) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        B_IDLE: begin
          if (!q_empty_i) begin
            job_q <= q_data_i;
            st_q  <= B_ANGLE;
          end
        end
        B_ANGLE: begin
          ang_q[0] <= 18'(job_q.ang_base);
          ang_q[1] <= b_ang;
          ang_q[2] <= be_ang;
          sel_q    <= 2'd0;
          st_q     <= B_CINIT;
        end
        B_CINIT: begin
          cx_q  <= ats_pkg::CORDIC_GAIN_Q30;
          cy_q  <= '0;
          cz_q  <= CW'(fold) <<< 17;
          neg_q <= (fold != ang_q[sel_q]);
          it_q  <= '0;
          st_q  <= B_CRUN;
        end
        B_CRUN: begin
          if (!cz_q[CW-1]) begin
            cx_q <= cx_q - ys;
            cy_q <= cy_q + xs;
            cz_q <= cz_q - ats_pkg::atan_q30(it_q);
          end else begin
            cx_q <= cx_q + ys;
            cy_q <= cy_q - xs;
            cz_q <= cz_q + ats_pkg::atan_q30(it_q);
          end
          if (it_q == 5'(CORDIC_ITERATIONS - 1)) begin
            st_q <= B_CSTORE;
          end else begin
            it_q <= it_q + 5'd1;
          end
        end
        B_CSTORE: begin
          cos_q[sel_q] <= neg_q ? -cx_q : cx_q;
          sin_q[sel_q] <= neg_q ? -cy_q : cy_q;
          if (sel_q == 2'd2) begin
            step_q <= '0;
            st_q   <= B_MUL;
          end else begin
            sel_q <= sel_q + 2'd1;
            st_q  <= B_CINIT;
          end
        end
        B_MUL: begin
          step_q <= step_q + 4'd1;
          case (step_q)
            4'd1:  acc_q   <= p_q;
            4'd2:  reach_q <= CW'(rnd68(acc_q + p_q, 20));
            4'd3:  acc_q   <= p_q;
            4'd4:  z_q     <= sat20(rnd68(acc_q + p_q, 30) +
                                    $signed({48'd0, base_height_um_i}));
            4'd5:  x_q     <= sat20(rnd68(p_q, 40));
            4'd6:  y_q     <= sat20(rnd68(p_q, 40));
            4'd7:  acc_q   <= p_q;
            4'd8:  acc_q   <= acc_q + p_q;
            4'd9:  d2_q    <= 42'(acc_q + p_q);
            4'd11: acc_q   <= p_q <<< 21;
            4'd12: begin
              sq_n_q <= 64'(acc_q + p_q);
              sq_r_q <= '0;
              sq_b_q <= 64'(1) << 62;
              st_q   <= B_SQRT;
            end
            default: ;
          endcase
        end
        B_SQRT: begin
          if (sq_n_q >= sq_t) begin
            sq_n_q <= sq_n_q - sq_t;
            sq_r_q <= (sq_r_q >> 1) + sq_b_q;
          end else begin
            sq_r_q <= sq_r_q >> 1;
          end
          sq_b_q <= sq_b_q >> 2;
          if (sq_b_q == 64'd1) begin
            st_q <= B_SPEED;
          end
        end
        B_SPEED: begin
          if (dt == '0) begin
            sp_q <= (sq_r_q != '0) ? ats_pkg::SPEED_MAX : '0;
            st_q <= B_HIST;
          end else begin
            dv_num_q <= 33'(sq_r_q[31:0]) + 33'(dt >> 1);
            dv_den_q <= dt;
            dv_rem_q <= '0;
            dv_cnt_q <= '0;
            st_q     <= B_DIV;
          end
        end
        B_DIV: begin
          dv_rem_q <= dv_ge ? 32'(dv_shift - {1'b0, dv_den_q}) : dv_shift[31:0];
          dv_num_q <= {dv_num_q[31:0], dv_ge};
          dv_cnt_q <= dv_cnt_q + 6'd1;
          if (dv_cnt_q == 6'd32) begin
            st_q <= B_HIST;
            sp_q <= sat_u20({dv_num_q[31:0], dv_ge});
          end
        end
        B_HIST: begin
          for (int i = AVERAGE_TAPS - 1; i > 0; i--) begin
            hist_q[i] <= hist_q[i-1];
          end
          hist_q[0] <= sp_q;
          if (cnt_q < CNT_W'(AVERAGE_TAPS + 1)) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
          valid_q <= (cnt_q >= CNT_W'(AVERAGE_TAPS));
          sum_q   <= '0;
          tap_q   <= '0;
          mean_q  <= '0;
          st_q    <= (cnt_q >= CNT_W'(AVERAGE_TAPS)) ? B_SUM : B_OUT;
        end
        B_SUM: begin
          sum_q <= sum_q + SUM_W'(hist_q[tap_q]);
          if (tap_q == TAP_IW'(AVERAGE_TAPS - 1)) begin
            st_q <= B_MEAN_LD;
          end else begin
            tap_q <= tap_q + TAP_IW'(1);
          end
        end
        B_MEAN_LD: begin
          mprod_q <= MP_W'(sum_q + SUM_W'(AVERAGE_TAPS / 2)) * MP_W'(MEAN_RECIP);
          st_q    <= B_MEAN_DONE;
        end
        B_MEAN_DONE: begin
          mean_q <= mean_sat;
          if (mean_sat > peak_q) begin
            peak_q <= mean_sat;
          end
          st_q <= B_OUT;
        end
        B_OUT: begin
          if (out_wr) begin
            out_valid_q       <= 1'b1;
            tip_x_um_o        <= x_q;
            tip_y_um_o        <= y_q;
            tip_z_um_o        <= z_q;
            speed_mm_s_o      <= sp_q;
            mean_speed_mm_s_o <= mean_q;
            mean_valid_o      <= valid_q;
            peak_mean_mm_s_o  <= peak_q;
            prev_x_q          <= x_q;
            prev_y_q          <= y_q;
            prev_z_q          <= z_q;
            prev_time_q       <= job_q.ts;
            st_q              <= B_IDLE;
          end
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

  `ATS_ASSERT_RST(a_peak_monotonic, clk_i, rst_ni, 1'b1 |=> peak_q >= $past(peak_q))
  `ATS_ASSERT_RST(a_mean_valid_count, clk_i, rst_ni,
                  out_valid_q && mean_valid_o |-> cnt_q == CNT_W'(AVERAGE_TAPS + 1))
  `ATS_ASSERT_RST(a_sqrt_bit_onehot, clk_i, rst_ni, st_q == B_SQRT |-> $onehot(sq_b_q))

endmodule

/* dv/arm_tip_speed_estimator_unit_checker.sv */
// checker: predicts tip position and speed per joint word and compares results
module arm_tip_speed_estimator_unit_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  logic               full,
  input  logic [12:0]        joint_base_mrad_i,
  input  logic [12:0]        joint_shoulder_mrad_i,
  input  logic [12:0]        joint_elbow_mrad_i,
  input  logic [31:0]        timestamp_us_i,
  input  logic               empty,
  input  logic               pop,
  input  logic signed [19:0] tip_x_um_o,
  input  logic signed [19:0] tip_y_um_o,
  input  logic signed [19:0] tip_z_um_o,
  input  logic [19:0]        speed_mm_s_o,
  input  logic [19:0]        mean_speed_mm_s_o,
  input  logic               mean_valid_o,
  input  logic [19:0]        peak_mean_mm_s_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [19:0]        cfg_wdata_i,
  output int                 fail_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [19:0] x, y, z;
    logic [19:0] spd, mean;
    logic valid;
    logic [19:0] peak;
  } tip_word_t;

  tip_word_t expected_tips[$];

  longint upper_len, fore_len, base_h;
  longint last_x, last_y, last_z;
  logic [31:0] last_ts;
  longint spd_hist[3];
  int n_seen;
  longint peak_sp;

  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v - 1) >>> s) - 1;
  endfunction

  function automatic longint round_shift(longint v, int s);
    longint h;
    h = longint'(1) << (s - 1);
    if (v >= 0) return (v + h) >>> s;
    return -((-v + h) >>> s);
  endfunction

  function automatic longint clamp_pos(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic longint angle_q13(logic [12:0] raw);
    longint m, v;
    m = longint'($signed(raw));
    if (m > ats_pkg::MRAD_LIMIT) m = ats_pkg::MRAD_LIMIT;
    if (m < -ats_pkg::MRAD_LIMIT) m = -ats_pkg::MRAD_LIMIT;
    v = m * 8192;
    if (v >= 0) return (v + 500) / 1000;
    return -((-v + 500) / 1000);
  endfunction

  function automatic longint wrap_angle(longint a);
    while (a > ats_pkg::PI_Q13) a -= ats_pkg::TWO_PI_Q13;
    while (a < -ats_pkg::PI_Q13) a += ats_pkg::TWO_PI_Q13;
    return a;
  endfunction

  function automatic longint arctan_step(int i);
    longint t[16] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
                      262144, 131072, 65536, 32768};
    return t[i];
  endfunction

  task automatic rotate(input longint a, output longint c, output longint s);
    longint z, x, y, nx;
    bit flip;
    z = a * 131072;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > longint'(ats_pkg::HALF_PI_Q13) * 131072) begin
      z -= longint'(ats_pkg::PI_Q13) * 131072;
      flip = 1;
    end else if (z < -longint'(ats_pkg::HALF_PI_Q13) * 131072) begin
      z += longint'(ats_pkg::PI_Q13) * 131072;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= arctan_step(i);
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += arctan_step(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic predict_tip(input logic [12:0] jb, js, je, input logic [31:0] ts);
    longint j1, b, be, c1, s1, cb, sb, cbe, sbe, reach, zq, x, y, z, dx, dy, dz;
    longint unsigned d2, nm, sp, dt, sum, mean;
    tip_word_t w;
    j1 = angle_q13(jb);
    b = wrap_angle(angle_q13(js) + ats_pkg::HALF_PI_Q13);
    be = wrap_angle(b + angle_q13(je));
    rotate(j1, c1, s1);
    rotate(b, cb, sb);
    rotate(be, cbe, sbe);
    reach = round_shift(upper_len * cb + fore_len * cbe, 20);
    x = clamp_pos(round_shift(c1 * reach, 40));
    y = clamp_pos(round_shift(s1 * reach, 40));
    zq = round_shift(upper_len * sb + fore_len * sbe, 30);
    z = clamp_pos(zq + base_h);
    dx = x - last_x;
    dy = y - last_y;
    dz = z - last_z;
    d2 = dx * dx + dy * dy + dz * dz;
    nm = int_sqrt(d2 * 1000000);
    dt = 64'(32'(ts - last_ts));
    if (dt == 0) sp = (nm != 0) ? 1048575 : 0;
    else sp = (nm + dt / 2) / dt;
    if (sp > 1048575) sp = 1048575;
    spd_hist[2] = spd_hist[1];
    spd_hist[1] = spd_hist[0];
    spd_hist[0] = sp;
    if (n_seen < 4) n_seen++;
    mean = 0;
    if (n_seen >= 4) begin
      sum = spd_hist[0] + spd_hist[1] + spd_hist[2];
      mean = (sum + 1) / 3;
      if (mean > 1048575) mean = 1048575;
      if (mean > peak_sp) peak_sp = mean;
    end
    last_x = x;
    last_y = y;
    last_z = z;
    last_ts = ts;
    w.x = 20'(x);
    w.y = 20'(y);
    w.z = 20'(z);
    w.spd = 20'(sp);
    w.mean = 20'(mean);
    w.valid = (n_seen >= 4);
    w.peak = 20'(peak_sp);
    expected_tips.insert(expected_tips.size(), w);
  endtask

  assign pending_count = expected_tips.size();

  always @(posedge clk_i or negedge rst_ni) begin
    tip_word_t e;
    if (!rst_ni) begin
      upper_len = 220000;
      fore_len = 150000;
      base_h = 55000;
      last_x = 0;
      last_y = 0;
      last_z = 0;
      last_ts = ats_pkg::PREV_TIME_RESET;
      spd_hist = '{0, 0, 0};
      n_seen = 0;
      peak_sp = 0;
      fail_count = 0;
      expected_tips.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ats_pkg::REG_UPPER_LINK:  upper_len = cfg_wdata_i;
          ats_pkg::REG_FOREARM:     fore_len = cfg_wdata_i;
          ats_pkg::REG_BASE_HEIGHT: base_h = cfg_wdata_i;
          default: ;
        endcase
      end
      if (!empty && pop) begin
        if (expected_tips.size() == 0) begin
          $display("%0t: unexpected word x=%0d", $time, tip_x_um_o);
          fail_count++;
        end else begin
          e = expected_tips.pop_front();
          if ({e.x, e.y, e.z, e.spd, e.mean, e.valid, e.peak} !==
              {tip_x_um_o, tip_y_um_o, tip_z_um_o, speed_mm_s_o, mean_speed_mm_s_o,
               mean_valid_o, peak_mean_mm_s_o}) begin
            $display("%0t: mismatch exp x=%0d y=%0d z=%0d spd=%0d mean=%0d v=%0b pk=%0d",
                     $time, e.x, e.y, e.z, e.spd, e.mean, e.valid, e.peak);
            $display("%0t:          act x=%0d y=%0d z=%0d spd=%0d mean=%0d v=%0b pk=%0d",
                     $time, tip_x_um_o, tip_y_um_o, tip_z_um_o, speed_mm_s_o,
                     mean_speed_mm_s_o, mean_valid_o, peak_mean_mm_s_o);
            fail_count++;
          end
        end
      end
      if (push && !full)
        predict_tip(joint_base_mrad_i, joint_shoulder_mrad_i, joint_elbow_mrad_i,
                    timestamp_us_i);
    end
  end
endmodule

/* dv/arm_tip_speed_estimator_unit_test.sv */
// testbench top: drives joint words and config writes, gives the verdict
module arm_tip_speed_estimator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i, rst_ni, push, full, empty, pop, mean_valid_o, cfg_we_i;
  logic [12:0] joint_base_mrad_i, joint_shoulder_mrad_i, joint_elbow_mrad_i;
  logic [31:0] timestamp_us_i;
  logic signed [19:0] tip_x_um_o, tip_y_um_o, tip_z_um_o;
  logic [19:0] speed_mm_s_o, mean_speed_mm_s_o, peak_mean_mm_s_o, cfg_wdata_i;
  logic [1:0] cfg_idx_i;
  int fail_count, pending_count, quiet_cycles;
  bit pop_hold, in_tail;
  logic [31:0] ts_now;

  arm_tip_speed_estimator_unit dut (.*);
  arm_tip_speed_estimator_unit_checker chk (.*);

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles > 20000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random bursts of stall, long hold when asked
  initial begin
    int n;
    pop = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (pop_hold) begin
        pop <= 0;
      end else if (!in_tail && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 19);
        pop <= 0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        pop <= 1;
      end
    end
  end

  // push stays high after the last word until the next word or drain
  task automatic send_word(input logic [12:0] jb, js, je, input logic [31:0] ts);
    int n;
    if (!in_tail && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 19);
      push <= 0;
      repeat (n) @(negedge clk_i);
    end
    push <= 1;
    joint_base_mrad_i <= jb;
    joint_shoulder_mrad_i <= js;
    joint_elbow_mrad_i <= je;
    timestamp_us_i <= ts;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [12:0] rand_angle();
    if ($urandom_range(0, 9) == 0) return 13'($urandom);
    return 13'($urandom_range(0, 6284) - 3142);
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: ts_now = $urandom;
        1: ts_now = ts_now;
        2: ts_now = ts_now + $urandom_range(1, 20);
        default: ts_now = ts_now + $urandom_range(1000, 20000);
      endcase
      send_word(rand_angle(), rand_angle(), rand_angle(), ts_now);
    end
  endtask

  task automatic drain();
    push <= 0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    @(negedge clk_i);
  endtask

  initial begin
    logic [12:0] edge_ang[6];
    edge_ang = '{13'h0FFF, 13'h1000, 13'd3142, -13'sd3142, 13'd0, 13'h1FFF};
    rst_ni = 0;
    push = 0;
    cfg_we_i = 0;
    cfg_idx_i = 0;
    cfg_wdata_i = 0;
    joint_base_mrad_i = 0;
    joint_shoulder_mrad_i = 0;
    joint_elbow_mrad_i = 0;
    timestamp_us_i = 0;
    pop_hold = 0;
    in_tail = 0;
    ts_now = 1000;
    repeat (3) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // first word at reset time, zero elapsed
    send_word(13'd0, 13'd0, 13'd0, 32'd1000);
    send_word(13'd0, 13'd0, 13'd0, 32'd1000);
    for (int i = 0; i < 6; i++)
      send_word(edge_ang[i], edge_ang[(i + 2) % 6], edge_ang[(i + 4) % 6], 32'd1001 + i);
    send_word(13'd1571, 13'd0, -13'sd1571, 32'hFFFF_FFF0);
    send_word(13'd0, 13'd1000, 13'd0, 32'h0000_0010);
    send_word(13'd0, 13'd1000, 13'd0, 32'h0000_0010);
    ts_now = 32'h10;
    drain();
    write_reg(ats_pkg::REG_UPPER_LINK, 20'd1000000);
    write_reg(ats_pkg::REG_FOREARM, 20'd1000000);
    write_reg(ats_pkg::REG_BASE_HEIGHT, 20'd1000000);
    write_reg(2'd3, 20'hFFFFF);
    send_word(13'd0, -13'sd1571, 13'd0, ts_now + 1);
    send_word(13'd0, 13'd0, 13'd0, ts_now + 2);
    ts_now += 2;
    send_random(200);
    drain();
    write_reg(ats_pkg::REG_UPPER_LINK, 20'd0);
    write_reg(ats_pkg::REG_FOREARM, 20'd0);
    write_reg(ats_pkg::REG_BASE_HEIGHT, 20'd0);
    send_random(150);
    drain();
    write_reg(ats_pkg::REG_UPPER_LINK, 20'hFFFFF);
    write_reg(ats_pkg::REG_FOREARM, 20'd1);
    write_reg(ats_pkg::REG_BASE_HEIGHT, 20'd524287);
    send_random(150);
    // long stall on the result side while words keep coming
    pop_hold = 1;
    fork
      send_random(20);
      begin
        int k;
        for (k = 0; k < 3000; k++) @(negedge clk_i);
        pop_hold = 0;
      end
    join
    drain();
    write_reg(ats_pkg::REG_UPPER_LINK, 20'($urandom_range(0, 1000000)));
    write_reg(ats_pkg::REG_FOREARM, 20'($urandom_range(0, 1000000)));
    write_reg(ats_pkg::REG_BASE_HEIGHT, 20'($urandom_range(0, 1000000)));
    send_random(600);
    drain();
    write_reg(ats_pkg::REG_UPPER_LINK, 20'd220000);
    write_reg(ats_pkg::REG_FOREARM, 20'd150000);
    write_reg(ats_pkg::REG_BASE_HEIGHT, 20'd55000);
    in_tail = 1;
    send_random(200);
    drain();
    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ats_pkg.sv
rtl/core/ats_front.sv
rtl/core/ats_fifo.sv
rtl/core/ats_back.sv
rtl/core/arm_tip_speed_estimator_unit.sv
dv/arm_tip_speed_estimator_unit_checker.sv
dv/arm_tip_speed_estimator_unit_test.sv
